// File: rtl/sepf_pkg.sv
// Shared types, constants and field layout for the session expiry packet filter.
// No dependencies; every other file in rtl/ imports this package.

package sepf_pkg;

   // session table geometry
   localparam int unsigned TABLE_DEPTH = 65536;
   localparam int unsigned TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned PORT_W      = 16;
   localparam logic [PORT_W:0] TABLE_DEPTH_EXT = (PORT_W + 1)'(TABLE_DEPTH);
   localparam logic [TABLE_AW-1:0] TABLE_LAST_ADDR = TABLE_AW'(TABLE_DEPTH - 1);

   // stored slot: only the two guard bits that drive the action are kept
   localparam int unsigned GUARD_KEEP_W = 2;
   localparam int unsigned TIME_W       = 64;
   localparam int unsigned SLOT_W       = GUARD_KEEP_W + TIME_W;

   // frame parsing (20-byte IP header assumed)
   localparam logic [5:0] POS_ETYPE_HI = 6'd12;
   localparam logic [5:0] POS_ETYPE_LO = 6'd13;
   localparam logic [5:0] POS_PROTO    = 6'd23;
   localparam logic [5:0] POS_SPORT_HI = 6'd34;
   localparam logic [5:0] POS_SPORT_LO = 6'd35;
   localparam logic [5:0] MIN_FRAME    = 6'd54;
   localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
   localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
   localparam logic [7:0] PROTO_TCP     = 8'd6;

   // command kinds carried in req_tuser
   localparam logic CMD_PKT_BYTE   = 1'b0;
   localparam logic CMD_SLOT_WRITE = 1'b1;

   // action codes
   localparam logic [1:0] ACTION_DROP = 2'd1;
   localparam logic [1:0] ACTION_PASS = 2'd2;

   // request tdata layout, lowest bit first
   localparam int unsigned REQ_TDATA_W = 216;
   localparam int unsigned REQ_BYTE_LSB   = 0;
   localparam int unsigned REQ_NOW_LSB    = 8;
   localparam int unsigned REQ_WIDX_LSB   = 72;
   localparam int unsigned REQ_GUARD_LSB  = 88;
   localparam int unsigned REQ_EXPIRY_LSB = 152;

   // response tdata layout, lowest bit first
   localparam int unsigned RSP_TDATA_W = 24;
   localparam int unsigned RSP_USED_W  = 19;

   // slot write toward the table
   typedef struct packed {
      logic                    en;
      logic [TABLE_AW-1:0]     addr;
      logic [GUARD_KEEP_W-1:0] guard;
      logic [TIME_W-1:0]       expiry;
   } slot_wr_type;

   // frame verdict context carried from the parse stage to the decision stage
   typedef struct packed {
      logic              lookup;
      logic              in_range;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] now;
   } verdict_ctx_type;

   // slot contents as read from the table
   typedef struct packed {
      logic [GUARD_KEEP_W-1:0] guard;
      logic [TIME_W-1:0]       expiry;
   } slot_rd_type;

endpackage

// File: rtl/sepf_table.sv
// Session table: guard bits and expiry time per slot, one write and one read port.
// Depends on sepf_pkg; clears every slot after reset, one slot per cycle.

module sepf_table
   import sepf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  slot_wr_type         slot_wr,
   input  logic                rd_en,
   input  logic [TABLE_AW-1:0] rd_addr,
   output slot_rd_type         rd_data,
   output logic                busy
);

   logic [SLOT_W-1:0]   mem [TABLE_DEPTH];
   logic [SLOT_W-1:0]   rd_data_ff;
   logic                clearing_ff;
   logic                clearing_in;
   logic [TABLE_AW-1:0] clear_addr_ff;
   logic [TABLE_AW-1:0] clear_addr_in;

   // clearing pass sweep
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == TABLE_LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // write port: clearing wins, commands are held off meanwhile
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (slot_wr.en) begin
         mem[slot_wr.addr] <= {slot_wr.guard, slot_wr.expiry};
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = slot_rd_type'(rd_data_ff);
   assign busy    = clearing_ff;

endmodule

// File: rtl/sepf_parse.sv
// Input stage: accepts request words, tracks frame header fields, issues slot writes.
// Depends on sepf_pkg; feeds sepf_table and the decision stage.

module sepf_parse
   import sepf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tuser,
   input  logic                   table_busy,
   input  logic                   stage_ready,
   output slot_wr_type            slot_wr,
   output logic                   rd_en,
   output logic [TABLE_AW-1:0]    rd_addr,
   output logic                   ctx_valid,
   output verdict_ctx_type        ctx
);

   logic [7:0]        pkt_byte;
   logic [TIME_W-1:0] now_time;
   logic [PORT_W-1:0] write_index;
   logic              accept;
   logic              frame_word;
   logic              frame_end;
   logic              s1_ready;

   logic [5:0]        pos_ff, pos_in;
   logic              etype_ok_ff, etype_ok_in;
   logic              proto_ok_ff, proto_ok_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic              ctx_valid_ff, ctx_valid_in;
   verdict_ctx_type   ctx_ff;

   // field extraction
   assign pkt_byte    = req_tdata[REQ_BYTE_LSB +: 8];
   assign now_time    = req_tdata[REQ_NOW_LSB +: TIME_W];
   assign write_index = req_tdata[REQ_WIDX_LSB +: PORT_W];

   // handshake
   assign s1_ready   = !ctx_valid_ff || stage_ready;
   assign req_tready = !table_busy && s1_ready;
   assign accept     = req_tvalid && req_tready;
   assign frame_word = accept && (req_tuser == CMD_PKT_BYTE);
   assign frame_end  = frame_word && req_tlast;

   // slot write command
   always_comb begin
      slot_wr.en     = accept && (req_tuser == CMD_SLOT_WRITE)
                       && ({1'b0, write_index} < TABLE_DEPTH_EXT);
      slot_wr.addr   = write_index[TABLE_AW-1:0];
      slot_wr.guard  = req_tdata[REQ_GUARD_LSB +: GUARD_KEEP_W];
      slot_wr.expiry = req_tdata[REQ_EXPIRY_LSB +: TIME_W];
   end

   // header field tracking
   always_comb begin
      etype_ok_in = etype_ok_ff;
      proto_ok_in = proto_ok_ff;
      port_in     = port_ff;
      pos_in      = pos_ff;
      case (pos_ff)
         POS_ETYPE_HI: etype_ok_in = (pkt_byte == ETYPE_IPV4_HI);
         POS_ETYPE_LO: etype_ok_in = etype_ok_ff && (pkt_byte == ETYPE_IPV4_LO);
         POS_PROTO:    proto_ok_in = (pkt_byte == PROTO_TCP);
         POS_SPORT_HI: port_in     = {pkt_byte, 8'h00};
         POS_SPORT_LO: port_in     = {port_ff[15:8], pkt_byte};
         default:      ;
      endcase
      if (pos_ff < MIN_FRAME) begin
         pos_in = pos_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         etype_ok_ff <= 1'b0;
         proto_ok_ff <= 1'b0;
         port_ff     <= '0;
      end else if (frame_end) begin
         pos_ff      <= '0;
         etype_ok_ff <= 1'b0;
         proto_ok_ff <= 1'b0;
         port_ff     <= '0;
      end else if (frame_word) begin
         pos_ff      <= pos_in;
         etype_ok_ff <= etype_ok_in;
         proto_ok_ff <= proto_ok_in;
         port_ff     <= port_in;
      end
   end

   // table read at the final byte; the port is complete well before it
   assign rd_en   = frame_end;
   assign rd_addr = port_ff[TABLE_AW-1:0];

   // verdict context register
   always_comb begin
      ctx_valid_in = ctx_valid_ff;
      if (s1_ready) begin
         ctx_valid_in = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_valid_ff <= 1'b0;
      end else begin
         ctx_valid_ff <= ctx_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         ctx_ff.lookup   <= (pos_in >= MIN_FRAME) && etype_ok_in && proto_ok_in;
         ctx_ff.in_range <= ({1'b0, port_in} < TABLE_DEPTH_EXT);
         ctx_ff.port     <= port_in;
         ctx_ff.now      <= now_time;
      end
   end

   assign ctx_valid = ctx_valid_ff;
   assign ctx       = ctx_ff;

endmodule

// File: rtl/sepf_decide.sv
// Decision stage: expiry check, guard masking and the response register.
// Depends on sepf_pkg; takes the verdict context and the slot read data.

module sepf_decide
   import sepf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ctx_valid,
   input  verdict_ctx_type        ctx,
   input  slot_rd_type            slot,
   output logic                   stage_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [TIME_W-1:0]       delta;
   logic                    live;
   logic [GUARD_KEEP_W-1:0] mask;
   logic [1:0]              action;
   logic                    checked;
   logic [PORT_W-1:0]       port;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_USED_W-1:0]   rsp_data_ff;

   // slot is live while expiry - now is not negative
   assign delta = slot.expiry - ctx.now;
   assign live  = !delta[TIME_W-1];
   assign mask  = slot.guard & {GUARD_KEEP_W{live}};

   always_comb begin
      action  = ACTION_PASS;
      checked = 1'b0;
      port    = '0;
      if (ctx.lookup) begin
         checked = 1'b1;
         port    = ctx.port;
         if (!ctx.in_range) begin
            action = ACTION_DROP;
         end else begin
            action = {mask[1], !mask[0]};
         end
      end
   end

   // response register
   assign stage_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_ready) begin
         rsp_valid_in = ctx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && ctx_valid) begin
         rsp_data_ff <= {port, checked, action};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_data_ff};

endmodule

// File: rtl/session_expiry_packet_filter.sv
// Top level of the session expiry packet filter.
// Depends on sepf_pkg, sepf_table, sepf_parse and sepf_decide.
//
//  channel | dir | tdata fields (low bit up)                        | tuser   | tlast
//  req_    | in  | pkt_byte, now_time, write_index, write_guard,    | command | pkt_last
//          |     | write_expiry (216 bits)                          |         |
//  rsp_    | out | action, table_checked, source_port, zero pad     | -       | -
//
// One request word per cycle while req_tready is high. After the frame's
// final byte the table read and verdict context are registered, then the
// expiry compare goes into the response register. After reset the table is
// cleared one slot per cycle, all TABLE_DEPTH (65536) slots, with
// req_tready low. A stalled response holds one verdict in the context
// register, and a stall drops req_tready only when both are full.

module session_expiry_packet_filter
   import sepf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pkt_byte[7:0], now_time[71:8], write_index[87:72],
   // write_guard[151:88], write_expiry[215:152]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   // command[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // action[1:0], table_checked[2], source_port[18:3], zero[23:19]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   slot_wr_type         slot_wr;
   logic                rd_en;
   logic [TABLE_AW-1:0] rd_addr;
   slot_rd_type         slot_rd;
   logic                table_busy;
   logic                stage_ready;
   logic                ctx_valid;
   verdict_ctx_type     ctx;

   // session table
   sepf_table u_table (
      .clock   (clock),
      .reset   (reset),
      .slot_wr (slot_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (slot_rd),
      .busy    (table_busy)
   );

   // input word handling and header parse
   sepf_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .table_busy  (table_busy),
      .stage_ready (stage_ready),
      .slot_wr     (slot_wr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .ctx_valid   (ctx_valid),
      .ctx         (ctx)
   );

   // verdict and response register
   sepf_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .ctx_valid   (ctx_valid),
      .ctx         (ctx),
      .slot        (slot_rd),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

`ifndef SYNTHESIS
   // no word taken while the table clearing pass runs
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      table_busy |-> !req_tready)
      else $error("request accepted during table clear");

   // a held verdict context keeps its port and time
   a_ctx_held: assert property (@(posedge clock) disable iff (reset)
      ctx_valid && !stage_ready |=> ctx_valid && $stable(ctx.port) && $stable(ctx.now))
      else $error("verdict context changed while stalled");

   // no table lookup means a pass with a zero port
   a_unchecked_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[1:0] == ACTION_PASS
                                     && rsp_tdata[18:3] == '0)
      else $error("unchecked frame not passed cleanly");

   // table read is issued only when the verdict register can take the frame
   a_read_with_ctx: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> ctx_valid)
      else $error("table read without a verdict context");
`endif

endmodule
